### hdl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg - shared types and tables for the base64 codec
// Job descriptor passed from front to back, queue sizing, alphabet mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

  // job queue between front and back
  localparam int JobQDepth = 2;
  localparam int JobQPtrW  = (JobQDepth > 1) ? $clog2(JobQDepth) : 1;
  localparam int JobQCntW  = $clog2(JobQDepth + 1);

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } codec_mode_e;

  // one item's worth of work: up to two data values, then pads
  typedef struct packed {
    logic [1:0][7:0] data;
    logic [1:0]      n_data;
    logic [1:0]      n_pad;
    logic            msg_end;
    logic            halted;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26)      return w + 8'd65;
    else if (s < 6'd52) return w + 8'd71;
    else if (s < 6'd62) return w - 8'd4;
    else if (s == 6'd62) return 8'h2B;
    else                 return 8'h2F;
  endfunction

  // character to {valid, 6-bit value}
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return 7'd0;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front - item intake and bit gathering
// Holds mode and message state, turns each accepted item into at most one job.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                push,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                byte_present_i,
  input  wire logic                message_end_i,
  input  wire b64_pkg::jobq_stat_t q_stat_i,
  output logic                     q_push_o,
  output b64_pkg::job_t            q_job_o
);

  b64_pkg::codec_mode_e mode_q;
  logic [5:0] buf_q, buf_d;
  logic [1:0] cnt_q, cnt_d;     // pending bits / 2
  logic [1:0] phase_q, phase_d;
  logic       halt_q, halt_d;

  logic        accept;
  logic [11:0] e_wide, d_wide;
  logic [6:0]  sx;
  logic [1:0]  nd, ph_after;
  b64_pkg::job_t job;

  assign accept = push && !q_stat_i.full;
  assign e_wide = {buf_q[3:0], data_byte_i};
  assign sx     = b64_pkg::dec_sextet(data_byte_i);
  assign d_wide = {buf_q, sx[5:0]};

  always_comb begin
    job      = '0;
    nd       = 2'd0;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    halt_d   = halt_q;
    ph_after = phase_q;
    q_push_o = 1'b0;
    if (mode_q == b64_pkg::ModeEncode) begin
      if (byte_present_i) begin
        unique case (cnt_q)
          2'd0: begin
            job.data[0] = b64_pkg::enc_char(e_wide[7:2]);
            nd    = 2'd1;
            buf_d = {4'd0, e_wide[1:0]};
            cnt_d = 2'd1;
          end
          2'd1: begin
            job.data[0] = b64_pkg::enc_char(e_wide[9:4]);
            nd    = 2'd1;
            buf_d = {2'd0, e_wide[3:0]};
            cnt_d = 2'd2;
          end
          2'd2: begin
            job.data[0] = b64_pkg::enc_char(e_wide[11:6]);
            job.data[1] = b64_pkg::enc_char(e_wide[5:0]);
            nd    = 2'd2;
            buf_d = 6'd0;
            cnt_d = 2'd0;
          end
          2'd3: begin
            // unreachable while encoding
            nd = 2'd0;
          end
        endcase
      end
      if (message_end_i) begin
        // flush leftover bits, zero-filled on the right
        if (cnt_d == 2'd1) begin
          job.data[nd[0]] = b64_pkg::enc_char({buf_d[1:0], 4'd0});
          nd = nd + 2'd1;
        end else if (cnt_d == 2'd2) begin
          job.data[nd[0]] = b64_pkg::enc_char({buf_d[3:0], 2'd0});
          nd = nd + 2'd1;
        end
      end
      ph_after  = phase_q + nd;
      job.n_pad = message_end_i ? (2'd0 - ph_after) : 2'd0;
      q_push_o  = accept && (byte_present_i || message_end_i);
    end else begin
      if (byte_present_i && !halt_q) begin
        if (!sx[6]) begin
          halt_d = 1'b1;
        end else begin
          unique case (cnt_q)
            2'd0: begin
              buf_d = sx[5:0];
              cnt_d = 2'd3;
            end
            2'd3: begin
              job.data[0] = d_wide[11:4];
              nd    = 2'd1;
              buf_d = {2'd0, d_wide[3:0]};
              cnt_d = 2'd2;
            end
            2'd2: begin
              job.data[0] = d_wide[9:2];
              nd    = 2'd1;
              buf_d = {4'd0, d_wide[1:0]};
              cnt_d = 2'd1;
            end
            2'd1: begin
              job.data[0] = d_wide[7:0];
              nd    = 2'd1;
              buf_d = 6'd0;
              cnt_d = 2'd0;
            end
          endcase
        end
      end
      job.halted = halt_d;
      q_push_o   = accept && ((nd != 2'd0) || message_end_i);
    end
    job.n_data  = nd;
    job.msg_end = message_end_i;
    phase_d     = ph_after;
  end

  assign q_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= b64_pkg::ModeEncode;
      buf_q   <= 6'd0;
      cnt_q   <= 2'd0;
      phase_q <= 2'd0;
      halt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q  <= b64_pkg::codec_mode_e'(cfg_wdata_i);
      buf_q   <= 6'd0;
      cnt_q   <= 2'd0;
      phase_q <= 2'd0;
      halt_q  <= 1'b0;
    end else if (accept) begin
      if (message_end_i) begin
        buf_q   <= 6'd0;
        cnt_q   <= 2'd0;
        phase_q <= 2'd0;
        halt_q  <= 1'b0;
      end else begin
        buf_q   <= buf_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        halt_q  <= halt_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/b64_jobq.sv
// ----------------------------------------------------------------------------
// b64_jobq - job queue between front and back
// Small FIFO of job descriptors; head is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_jobq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire b64_pkg::job_t       job_i,
  input  wire logic                pop_i,
  output b64_pkg::job_t            head_o,
  output b64_pkg::jobq_stat_t      stat_o
);

  localparam int PtrW = b64_pkg::JobQPtrW;
  localparam int CntW = b64_pkg::JobQCntW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(b64_pkg::JobQDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(b64_pkg::JobQDepth);

  b64_pkg::job_t mem_q [b64_pkg::JobQDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back - result sequencer
// Walks the head job one result per cycle, while the output is popped or empty, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b64_pkg::job_t       head_i,
  input  wire b64_pkg::jobq_stat_t q_stat_i,
  output logic                     q_pop_o,
  input  wire logic                pop,
  output logic                     empty,
  output logic [7:0]               out_byte_o,
  output logic                     out_present_o,
  output logic                     run_last_o,
  output logic                     message_done_o,
  output logic                     decode_halted_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  logic [2:0] total, total_eff;
  logic       is_last, adv;
  logic [7:0] r_byte;
  logic       r_present;

  assign total     = {1'b0, head_i.n_data} + {1'b0, head_i.n_pad};
  assign total_eff = (total == 3'd0) ? 3'd1 : total;
  assign is_last   = (idx_q == total_eff - 3'd1);
  assign adv       = !q_stat_i.empty && (!out_valid_q || pop);
  assign q_pop_o   = adv && is_last;
  assign empty     = !out_valid_q;

  always_comb begin
    if (idx_q < {1'b0, head_i.n_data}) begin
      r_byte    = head_i.data[idx_q[0]];
      r_present = 1'b1;
    end else if (idx_q < total) begin
      r_byte    = b64_pkg::PadChar;
      r_present = 1'b1;
    end else begin
      // end marker with no data
      r_byte    = 8'd0;
      r_present = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_o      <= r_byte;
      out_present_o   <= r_present;
      run_last_o      <= is_last;
      message_done_o  <= is_last && head_i.msg_end;
      decode_halted_o <= head_i.halted;
    end
  end

endmodule

`default_nettype wire

### hdl/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec - streaming base64 encoder / decoder, standard alphabet
// Front end gathers bits per item, job queue, back end emits results.
// ----------------------------------------------------------------------------
// Usage: write the mode (0 encode, 1 decode) while the block is idle; a write
// also drops any message in progress. Items enter through push/full and
// results leave through empty/pop. An item is taken whenever the two-entry
// job queue has room, so input runs back to back. The back end sends one
// result per cycle while the output is popped or empty; an item gives one or
// two characters per byte when encoding (four characters per three bytes of
// input on a long run), one byte per character or none when decoding, and up
// to four at a message end with flush and '=' padding. The result rate of one
// per cycle, set by the output register, bounds the sustained throughput.
// Items with no byte and no end give no result; a message end that produces
// nothing gives a single marker result.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // mode register
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // item input
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       message_end_i,
  // results
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            out_present_o,
  output logic            run_last_o,
  output logic            message_done_o,
  output logic            decode_halted_o
);

  b64_pkg::job_t       q_job, q_head;
  b64_pkg::jobq_stat_t q_stat;
  logic                q_push, q_pop;

  assign full = q_stat.full;

  // intake: classify item, update bit buffer, build the job
  b64_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_job_o        (q_job)
  );

  // decouples intake from result delivery
  b64_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // expands each job into results, one per cycle while the output is popped or empty
  b64_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .q_stat_i        (q_stat),
    .q_pop_o         (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_byte_o      (out_byte_o),
    .out_present_o   (out_present_o),
    .run_last_o      (run_last_o),
    .message_done_o  (message_done_o),
    .decode_halted_o (decode_halted_o)
  );

  // front never writes a job into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("job written into full queue");

  // back only retires a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("job retired from empty queue");

  // message end closes the item's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && message_done_o) |-> run_last_o)
    else $error("message done without run last");

  // a marker result only closes a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_present_o) |-> (message_done_o && out_byte_o == 8'd0))
    else $error("marker result outside message end");

endmodule

`default_nettype wire
